// ===== hw/rtl/lrcdf_pkg.sv =====
package lrcdf_pkg;

	// frame layout
	localparam int unsigned HDR_LEN = 5;
	localparam int unsigned CNT_W   = 9;

	// crc-16/ccitt-false
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	// header byte positions
	localparam int unsigned HDR_SUM    = 0;
	localparam int unsigned HDR_ID     = 1;
	localparam int unsigned HDR_LENGTH = 2;
	localparam int unsigned HDR_CRC_LO = 3;
	localparam int unsigned HDR_CRC_HI = 4;

	// one result beat
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       has_byte;
		logic [7:0] packet_id;
		logic [7:0] payload_length;
		logic       frame_last;
		logic       crc_ok;
	} result_t;

endpackage

// ===== hw/rtl/lrc_crc16_packet_deframer.sv =====
// Packet deframer: takes one received byte per beat on data_* and hunts for a
// five-byte header (checksum, id, length, crc low, crc high) whose bytes sum
// to zero modulo 256, sliding one byte at a time on a bad header. Each payload
// byte comes out as one result beat with its index; the beat that ends a frame
// has frame_last set and crc_ok gives the CRC-16/CCITT-FALSE check of the
// payload. An empty frame gives a single beat with has_byte clear. Header and
// rejected bytes give no beat. Sustained rate is one byte per clock while
// results are taken; an accepted byte sits in the input register and moves
// into the result register when that register is free or being emptied, and
// its result is then shown on the outputs. A stalled result holds the input
// register, and the input stalls once both registers are full.
// The clock period is set by the byte-wide crc update (eight chained
// polynomial steps) in front of the result register.
module lrc_crc16_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic       has_byte,
	output logic [7:0] packet_id,
	output logic [7:0] payload_length,
	output logic       frame_last,
	output logic       crc_ok
);
	import lrcdf_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	logic       emit;
	result_t    res_c;
	logic       res_valid_q;
	result_t    res_q;

	// stage one moves when the result register is free or being emptied
	assign advance    = !res_valid_q || result_ready;
	assign data_ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	lrcdf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.emit    (emit),
		.result  (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res_c;
		end
	end

	assign result_valid   = res_valid_q;
	assign payload_byte   = res_q.payload_byte;
	assign byte_index     = res_q.byte_index;
	assign has_byte       = res_q.has_byte;
	assign packet_id      = res_q.packet_id;
	assign payload_length = res_q.payload_length;
	assign frame_last     = res_q.frame_last;
	assign crc_ok         = res_q.crc_ok;

endmodule

// ===== hw/rtl/lrcdf_crc16.sv =====
module lrcdf_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import lrcdf_pkg::*;

	// one byte, msb first, eight polynomial steps
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== hw/rtl/lrcdf_core.sv =====
module lrcdf_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	output logic              emit,
	output lrcdf_pkg::result_t result
);
	import lrcdf_pkg::*;

	logic [7:0]       window_q [HDR_LEN];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] flen_q;
	logic [15:0]      crc_q;

	logic [7:0]       window_d [HDR_LEN];
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] flen_d;
	logic [15:0]      crc_d;
	logic [15:0]      crc_upd;

	lrcdf_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (byte_in),
		.crc_out (crc_upd)
	);

	// header search and payload tracking
	always_comb begin
		logic [7:0]       win [HDR_LEN];
		logic [7:0]       sum;
		logic [CNT_W-1:0] cnt1;
		logic [15:0]      hdr_crc;
		win      = window_q;
		sum      = 8'h00;
		hdr_crc  = 16'h0000;
		cnt1     = count_q + CNT_W'(1);
		window_d = window_q;
		count_d  = count_q;
		flen_d   = flen_q;
		crc_d    = crc_q;
		emit     = 1'b0;
		result   = '0;
		if (count_q < CNT_W'(HDR_LEN)) begin
			// header byte: place it in the window
			for (int i = 0; i < HDR_LEN; i++) begin
				if (count_q[2:0] == 3'(i)) begin
					win[i] = byte_in;
				end
			end
			window_d = win;
			count_d  = cnt1;
			if (cnt1 == CNT_W'(HDR_LEN)) begin
				for (int i = 0; i < HDR_LEN; i++) begin
					sum = sum + win[i];
				end
				hdr_crc = {win[HDR_CRC_HI], win[HDR_CRC_LO]};
				if (sum != 8'h00) begin
					// bad header: drop the oldest byte
					for (int i = 0; i < HDR_LEN - 1; i++) begin
						window_d[i] = win[i+1];
					end
					count_d = CNT_W'(HDR_LEN - 1);
				end else begin
					flen_d = CNT_W'(HDR_LEN) + {1'b0, win[HDR_LENGTH]};
					crc_d  = CRC_INIT;
					if (win[HDR_LENGTH] == 8'h00) begin
						// empty frame ends on its last header byte
						count_d               = '0;
						emit                  = 1'b1;
						result.packet_id      = win[HDR_ID];
						result.payload_length = win[HDR_LENGTH];
						result.frame_last     = 1'b1;
						result.crc_ok         = (hdr_crc == CRC_INIT);
					end
				end
			end
		end else begin
			// payload byte
			hdr_crc               = {window_q[HDR_CRC_HI], window_q[HDR_CRC_LO]};
			crc_d                 = crc_upd;
			count_d               = cnt1;
			emit                  = 1'b1;
			result.payload_byte   = byte_in;
			result.byte_index     = 8'(count_q - CNT_W'(HDR_LEN));
			result.has_byte       = 1'b1;
			result.packet_id      = window_q[HDR_ID];
			result.payload_length = window_q[HDR_LENGTH];
			if (cnt1 >= flen_q || cnt1 < CNT_W'(HDR_LEN)) begin
				count_d           = '0;
				result.frame_last = 1'b1;
				result.crc_ok     = (crc_upd == hdr_crc);
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HDR_LEN; i++) begin
				window_q[i] <= 8'h00;
			end
			count_q <= '0;
			flen_q  <= '0;
			crc_q   <= CRC_INIT;
		end else if (step) begin
			window_q <= window_d;
			count_q  <= count_d;
			flen_q   <= flen_d;
			crc_q    <= crc_d;
		end
	end

endmodule

// ===== hw/rtl/lrcdf_checker.sv =====
module lrcdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] payload_byte,
	input logic [7:0] byte_index,
	input logic       has_byte,
	input logic [7:0] packet_id,
	input logic [7:0] payload_length,
	input logic       frame_last,
	input logic       crc_ok
);

	// crc verdict only on the closing beat
	a_crc_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_last |-> !crc_ok)
		else $error("crc_ok set on a beat that does not end the frame");

	// an empty-frame beat is a bare closing beat
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |->
			frame_last && payload_byte == 8'h00 && byte_index == 8'h00 &&
			payload_length == 8'h00)
		else $error("malformed empty-frame beat");

	// payload index stays inside the announced length
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && has_byte |-> byte_index < payload_length)
		else $error("payload index beyond frame length");

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(payload_byte) && $stable(byte_index) &&
			$stable(packet_id) && $stable(frame_last) && $stable(crc_ok))
		else $error("result beat changed while stalled");

endmodule

bind lrc_crc16_packet_deframer lrcdf_checker u_lrcdf_checker (.*);
